>>> rtl/pra_pkg.sv
package pra_pkg;

  localparam int CfgW = 29;
  localparam int PageW = 28;
  localparam int CntW = 29;
  localparam int AddrFieldW = 40;

  localparam logic [1:0] FUNC_ALLOC = 2'd0;
  localparam logic [1:0] FUNC_FREE  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_RSVD  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_INVAL = 2'd1;
  localparam logic [1:0] ST_NOMEM = 2'd2;

  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

  typedef struct packed {
    logic [1:0]            func;
    logic [AddrFieldW-1:0] addr_in;
    logic [CntW-1:0]       count;
  } in_word_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [AddrFieldW-1:0] addr_out;
    logic [CntW-1:0]       avail_pages;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RD,
    S_CMP,
    S_ALLOC_HIT,
    S_ALLOC_LAST,
    S_ALLOC_MOVE,
    S_CURSOR,
    S_FREE_RET,
    S_FREE_HIT,
    S_APPEND,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    M_ALLOC,
    M_ABSORB,
    M_MERGE
  } mode_t;

  typedef struct packed {
    logic load;
    logic clr_scan;
    logic rd;
    logic inc_scan;
    logic rd_last;
    logic alloc_hit;
    logic alloc_move;
    logic alloc_cursor;
    logic free_ret;
    logic merge;
    logic append;
    logic clear;
    logic fail_inval;
    logic fail_nomem;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       cnt_zero;
    logic       free_bad;
    logic       ends_at_cursor;
    logic       scan_end;
    logic       hit;
    logic       exact;
    logic       fits_cursor;
    logic       list_full;
  } sts_t;

endpackage

>>> rtl/page_run_allocator.sv
// Page run allocator.
// Command channel: pulse start with func/addr_in/count in cmd_word while busy
// is low; the word is taken on that edge and busy rises.
// func 0 allocates count pages, 1 frees a run at addr_in, 2 clears the
// cursor and free list. Exactly one result word follows per command on
// rsp with rsp_valid high for one cycle; the receiver cannot stall.
// A clear or rejected command goes straight to the result; allocate and
// free scan the free list entry by entry through the list RAM read port.
// Commands do not overlap: busy drops in the cycle the result is shown,
// so the next command can be taken there.
// Configuration: cfg_we with cfg_idx 0 (base page) or 1 (window size);
// any write clears the cursor and list. Write only while busy is low.
// Reset clears the window, cursor and list; list RAM contents need no
// clearing since only entries below the run count are read.
module page_run_allocator
  import pra_pkg::*;
#(
  parameter int PAGE_SHIFT = 12,
  parameter int MAX_RUNS = 16,
  parameter int ADDR_WIDTH = 40
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  in_word_t        cmd_word,
  output logic            rsp_valid,
  output out_word_t       rsp,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [CfgW-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  pra_ctrl u_ctrl (.clk, .rst, .start, .busy, .sts, .cmd);

  pra_dp #(.PageShift(PAGE_SHIFT), .MaxRuns(MAX_RUNS), .AddrWidth(ADDR_WIDTH)) u_dp (
    .clk, .rst, .in_word(cmd_word), .cfg_we, .cfg_idx, .cfg_data,
    .cmd, .sts, .out_word(rsp), .out_valid(rsp_valid)
  );

endmodule

>>> rtl/pra_ram.sv
module pra_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/pra_ctrl.sv
module pra_ctrl
  import pra_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;
  mode_t  mode, mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= M_ALLOC;
    end else begin
      state <= state_next;
      mode  <= mode_next;
    end
  end

  always_comb begin
    state_next = state;
    mode_next  = mode;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (sts.func == FUNC_CLEAR) begin
          state_next = S_DONE;
        end else if (sts.func == FUNC_ALLOC && !sts.cnt_zero) begin
          mode_next = M_ALLOC;
          state_next = S_RD;
        end else if (sts.func == FUNC_FREE && !sts.cnt_zero && !sts.free_bad) begin
          if (sts.ends_at_cursor) begin
            state_next = S_FREE_RET;
          end else begin
            mode_next = M_MERGE;
            state_next = S_RD;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_FREE_RET: begin
        mode_next = M_ABSORB;
        state_next = S_RD;
      end
      S_RD: begin
        if (sts.scan_end) begin
          unique case (mode)
            M_ALLOC:  state_next = S_CURSOR;
            M_ABSORB: state_next = S_DONE;
            default:  state_next = S_APPEND;
          endcase
        end else begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        if (sts.hit) begin
          unique case (mode)
            M_ALLOC:  state_next = sts.exact ? S_ALLOC_LAST : S_ALLOC_HIT;
            M_ABSORB: state_next = S_ALLOC_LAST;
            default:  state_next = S_FREE_HIT;
          endcase
        end else begin
          state_next = S_RD;
        end
      end
      S_ALLOC_LAST: state_next = S_ALLOC_MOVE;
      default:      state_next = (state == S_DONE) ? S_IDLE : S_DONE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = (state != S_IDLE);
    unique case (state)
      S_IDLE:  cmd.load = start;
      S_CHECK: begin
        cmd.clr_scan = 1'b1;
        cmd.clear = (sts.func == FUNC_CLEAR);
        cmd.fail_inval = (sts.func == FUNC_RSVD) ||
                         (sts.func != FUNC_CLEAR && sts.cnt_zero) ||
                         (sts.func == FUNC_FREE && sts.free_bad);
      end
      S_FREE_RET: cmd.free_ret = 1'b1;
      S_RD:       cmd.rd = 1'b1;
      S_CMP:      cmd.inc_scan = !sts.hit;
      S_ALLOC_HIT: begin
        cmd.alloc_hit = 1'b1;
      end
      S_ALLOC_LAST: cmd.rd_last = 1'b1;
      S_ALLOC_MOVE: begin
        cmd.alloc_move = 1'b1;
      end
      S_CURSOR: begin
        cmd.alloc_cursor = sts.fits_cursor;
        cmd.fail_nomem = !sts.fits_cursor;
      end
      S_FREE_HIT: cmd.merge = 1'b1;
      S_APPEND: begin
        cmd.append = !sts.list_full;
        cmd.fail_nomem = sts.list_full;
      end
      S_DONE: cmd.done = 1'b1;
      default: ;
    endcase
  end

endmodule

>>> rtl/pra_dp.sv
module pra_dp
  import pra_pkg::*;
#(
  parameter int PageShift = 12,
  parameter int MaxRuns = 16,
  parameter int AddrWidth = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  in_word_t            in_word,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [CfgW-1:0]     cfg_data,
  input  cmd_t                cmd,
  output sts_t                sts,
  output out_word_t           out_word,
  output logic                out_valid
);

  localparam int IdxW = $clog2(MaxRuns);
  localparam int TotW = $clog2(MaxRuns + 1);
  localparam int EntW = PageW + CntW;
  localparam int PgW = AddrWidth - PageShift;
  localparam int SumW = ((PgW > CntW) ? PgW : CntW) + 1;

  logic [PageW-1:0] base_page;
  logic [CntW-1:0]  size_pages, taken_pages, listed_pages;
  logic [TotW-1:0]  run_total;
  logic [TotW-1:0]  scan;
  logic [IdxW-1:0]  hit_idx;
  in_word_t         req;
  logic [1:0]       status;
  logic [AddrWidth-1:0] addr_res;
  logic             absorb_mode;

  logic             we;
  logic [IdxW-1:0]  waddr, raddr;
  logic [EntW-1:0]  wdata, rdata;
  logic [PageW-1:0] e_start;
  logic [CntW-1:0]  e_len;

  pra_ram #(.Width(EntW), .Depth(MaxRuns)) u_ram (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign e_start = rdata[EntW-1:CntW];
  assign e_len   = rdata[CntW-1:0];

  logic [AddrWidth-1:0] a_masked;
  logic [PgW-1:0]       pg;
  logic [SumW-1:0]      pg_w, base_w, taken_w, cnt_w;
  logic [SumW-1:0]      offset, end_pg, cursor, e_end;
  logic                 start_at_end;
  logic [CntW:0]        avail;

  assign a_masked = AddrWidth'(req.addr_in);
  assign pg = a_masked[AddrWidth-1:PageShift];
  assign pg_w = SumW'(pg);
  assign base_w = SumW'(base_page);
  assign taken_w = SumW'(taken_pages);
  assign cnt_w = SumW'(req.count);
  assign offset = pg_w - base_w;
  assign end_pg = pg_w + cnt_w;
  assign cursor = base_w + taken_w;
  assign e_end = SumW'(e_start) + SumW'(e_len);
  assign start_at_end = (SumW'(e_start) == end_pg);
  assign avail = {1'b0, size_pages} - {1'b0, taken_pages};

  assign sts.func = req.func;
  assign sts.cnt_zero = (req.count == '0);
  assign sts.free_bad = (a_masked[PageShift-1:0] != '0) ||
                        (base_w > pg_w) ||
                        (offset >= taken_w) ||
                        (cnt_w > taken_w - offset);
  assign sts.ends_at_cursor = (end_pg == cursor);
  assign sts.scan_end = (scan >= run_total);
  assign sts.exact = (e_len == req.count);
  assign sts.fits_cursor = ({1'b0, req.count} <= avail);
  assign sts.list_full = (run_total >= TotW'(MaxRuns));
  assign sts.hit = (req.func == FUNC_ALLOC) ? (e_len >= req.count) :
                   absorb_mode ? (e_end == cursor) :
                   (start_at_end || (e_end == pg_w));

  always_comb begin
    we = 1'b0;
    waddr = hit_idx;
    wdata = rdata;
    raddr = scan[IdxW-1:0];
    if (cmd.rd_last) raddr = IdxW'(run_total - TotW'(1));
    if (cmd.alloc_hit) begin
      we = 1'b1;
      wdata = {e_start + PageW'(req.count), e_len - req.count};
    end else if (cmd.alloc_move) begin
      we = 1'b1;
    end else if (cmd.merge) begin
      we = 1'b1;
      if (start_at_end)
        wdata = {PageW'(pg), e_len + req.count};
      else
        wdata = {e_start, e_len + req.count};
    end else if (cmd.append) begin
      we = 1'b1;
      waddr = IdxW'(run_total);
      wdata = {PageW'(pg), req.count};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_page <= '0;
      size_pages <= '0;
      taken_pages <= '0;
      listed_pages <= '0;
      run_total <= '0;
      scan <= '0;
      absorb_mode <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.done;
      if (cfg_we) begin
        if (cfg_idx == CFG_BASE) base_page <= cfg_data[PageW-1:0];
        else size_pages <= cfg_data[CntW-1:0];
        taken_pages <= '0;
        listed_pages <= '0;
        run_total <= '0;
      end
      if (cmd.load) begin
        req <= in_word;
        status <= ST_OK;
        addr_res <= '0;
        absorb_mode <= 1'b0;
      end
      if (cmd.clr_scan) scan <= '0;
      if (cmd.inc_scan) scan <= scan + TotW'(1);
      if (cmd.rd) hit_idx <= scan[IdxW-1:0];
      if (cmd.clear) begin
        taken_pages <= '0;
        listed_pages <= '0;
        run_total <= '0;
      end
      if (cmd.fail_inval) status <= ST_INVAL;
      if (cmd.fail_nomem) status <= ST_NOMEM;
      if (cmd.alloc_hit || (cmd.rd_last && !absorb_mode)) begin
        addr_res <= AddrWidth'({e_start, {PageShift{1'b0}}});
        listed_pages <= listed_pages - req.count;
      end
      if (cmd.rd_last && absorb_mode) begin
        taken_pages <= (e_len > taken_pages) ? '0 : taken_pages - e_len;
        listed_pages <= listed_pages - e_len;
      end
      if (cmd.alloc_move) run_total <= run_total - TotW'(1);
      if (cmd.alloc_cursor) begin
        addr_res <= AddrWidth'({cursor, {PageShift{1'b0}}});
        taken_pages <= taken_pages + req.count;
      end
      if (cmd.free_ret) begin
        taken_pages <= taken_pages - req.count;
        absorb_mode <= 1'b1;
        scan <= '0;
      end
      if (cmd.merge || cmd.append) listed_pages <= listed_pages + req.count;
      if (cmd.append) run_total <= run_total + TotW'(1);
    end
  end

  assign out_word.status = status;
  assign out_word.addr_out = (status == ST_OK) ?
                             AddrFieldW'(addr_res) : '0;
  assign out_word.avail_pages = size_pages - taken_pages + listed_pages;

  assert property (@(posedge clk) disable iff (rst) run_total <= TotW'(MaxRuns))
    else $error("run count exceeds list depth");
  assert property (@(posedge clk) disable iff (rst) cmd.append |-> !sts.list_full)
    else $error("append into full list");
  assert property (@(posedge clk) disable iff (rst) cmd.alloc_move |-> run_total != '0)
    else $error("drop from empty list");

endmodule
